// ----- rtl/par_pkg.sv -----
// Shared types, widths and CORDIC constants for the point axis rotation unit.
package par_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;

  localparam int CORD_W = 34;
  localparam int RES_W  = 33;
  localparam int TRIG_W = 32;
  localparam int PROD_W = COORD_WIDTH + 1 + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - 30;
  localparam int EXT_W  = RND_W + 1;

  localparam logic signed [CORD_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CORD_W-1:0] ONE_Q30  = 34'sd1073741824;
  localparam logic [31:0]              EIGHTH_TURN = 32'h2000_0000;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   diff_t;
  typedef logic signed [TRIG_W-1:0]      trig_t;

  typedef struct packed {
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;
    logic [ANGLE_WIDTH-1:0] angle;
    axis_t                  axis;
    coord_t                 center_x;
    coord_t                 center_y;
    coord_t                 center_z;
  } point_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
    logic   saturated;
  } result_t;

  typedef struct packed {
    point_t item;
    diff_t  da;
    diff_t  db;
  } ctx_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [RES_W-1:0]  resid;
    logic [1:0]               quad;
  } cord_t;

endpackage

// ----- rtl/par_prep.sv -----
// Input stage: center offsets, off-axis pair selection and angle reduction.
module par_prep import par_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  point_t item,
  output logic   out_valid,
  output ctx_t   ctx,
  output cord_t  cord
);

  diff_t       dx, dy, dz;
  logic [31:0] wide, shifted;
  ctx_t        ctx_next;
  cord_t       cord_next;

  always_comb begin
    dx = diff_t'(item.point_x) - diff_t'(item.center_x);
    dy = diff_t'(item.point_y) - diff_t'(item.center_y);
    dz = diff_t'(item.point_z) - diff_t'(item.center_z);
    ctx_next.item = item;
    unique case (item.axis)
      AXIS_X: begin
        ctx_next.da = dy;
        ctx_next.db = dz;
      end
      AXIS_Y: begin
        ctx_next.da = dz;
        ctx_next.db = dx;
      end
      default: begin
        ctx_next.da = dx;
        ctx_next.db = dy;
      end
    endcase
    wide = {item.angle, {(32 - ANGLE_WIDTH){1'b0}}};
    shifted = wide + EIGHTH_TURN;
    cord_next.x = GAIN_Q30;
    cord_next.y = '0;
    cord_next.quad = shifted[31:30];
    cord_next.resid = {3'b000, shifted[29:0]} - {1'b0, EIGHTH_TURN};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx <= ctx_next;
      cord <= cord_next;
    end
  end

endmodule

// ----- rtl/par_cordic.sv -----
// Unrolled CORDIC rotation pipeline, one micro-rotation per register stage.
module par_cordic import par_pkg::*; #(
  parameter int STAGES = 18
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  ctx_t  in_ctx,
  input  cord_t in_cord,
  output logic  out_valid,
  output ctx_t  out_ctx,
  output cord_t out_cord
);

  logic  vld [STAGES];
  cord_t st  [STAGES];
  ctx_t  cx  [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                     sv;
    cord_t                    sc;
    ctx_t                     sx;
    logic signed [CORD_W-1:0] xs, ys;
    logic                     up;
    cord_t                    nc;

    if (i == 0) begin : g_first
      assign sv = in_valid;
      assign sc = in_cord;
      assign sx = in_ctx;
    end else begin : g_next
      assign sv = vld[i-1];
      assign sc = st[i-1];
      assign sx = cx[i-1];
    end

    always_comb begin
      xs = sc.x >>> i;
      ys = sc.y >>> i;
      up = !sc.resid[RES_W-1];
      nc.quad = sc.quad;
      if (up) begin
        nc.x = sc.x - ys;
        nc.y = sc.y + xs;
        nc.resid = sc.resid - RES_W'(ATAN_TURNS[i]);
      end else begin
        nc.x = sc.x + ys;
        nc.y = sc.y - xs;
        nc.resid = sc.resid + RES_W'(ATAN_TURNS[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= nc;
        cx[i] <= sx;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_ctx   = cx[STAGES-1];
  assign out_cord  = st[STAGES-1];

endmodule

// ----- rtl/par_mix.sv -----
// Back end: quadrant fold, products, rounding, center add-back and saturation.
module par_mix import par_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  ctx_t    in_ctx,
  input  cord_t   in_cord,
  output logic    out_valid,
  output result_t out_data
);

  localparam logic signed [EXT_W-1:0] HI = EXT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] LO = -HI - EXT_W'(1);
  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << 29;
  localparam logic [SUM_W-1:0] HALF_P1 = HALF + SUM_W'(1);

  function automatic trig_t clamp_trig(input logic signed [CORD_W-1:0] v);
    if (v > ONE_Q30) begin
      return TRIG_W'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      return TRIG_W'(-ONE_Q30);
    end
    return TRIG_W'(v);
  endfunction

  function automatic coord_t clamp_coord(input logic signed [EXT_W-1:0] v);
    if (v > HI) begin
      return COORD_WIDTH'(HI);
    end else if (v < LO) begin
      return COORD_WIDTH'(LO);
    end
    return COORD_WIDTH'(v);
  endfunction

  logic                     v1, v2, v3, v4;
  ctx_t                     cx1, cx2, cx3, cx4;
  trig_t                    cos1, sin1;
  logic signed [PROD_W-1:0] ca2, sb2, sa2, cb2;
  logic signed [SUM_W-1:0]  suma3, sumb3;
  logic [RND_W-1:0]         rnda4, rndb4;
  logic                     nega4, negb4;

  logic signed [CORD_W-1:0] c_raw, s_raw;
  logic [SUM_W-1:0]         maga, magb;
  coord_t                   ctra, ctrb, qa, qb;
  logic signed [EXT_W-1:0]  ea, eb, ra, rb;
  logic                     hita, hitb;
  result_t                  res_next;

  always_comb begin
    case (in_cord.quad)
      2'd0: begin
        c_raw = in_cord.x;
        s_raw = in_cord.y;
      end
      2'd1: begin
        c_raw = -in_cord.y;
        s_raw = in_cord.x;
      end
      2'd2: begin
        c_raw = -in_cord.x;
        s_raw = -in_cord.y;
      end
      default: begin
        c_raw = in_cord.y;
        s_raw = -in_cord.x;
      end
    endcase
  end

  always_comb begin
    maga = suma3[SUM_W-1] ? (~suma3 + HALF_P1) : (suma3 + HALF);
    magb = sumb3[SUM_W-1] ? (~sumb3 + HALF_P1) : (sumb3 + HALF);
  end

  always_comb begin
    unique case (cx4.item.axis)
      AXIS_X: begin
        ctra = cx4.item.center_y;
        ctrb = cx4.item.center_z;
      end
      AXIS_Y: begin
        ctra = cx4.item.center_z;
        ctrb = cx4.item.center_x;
      end
      default: begin
        ctra = cx4.item.center_x;
        ctrb = cx4.item.center_y;
      end
    endcase
    ea = EXT_W'(ctra);
    eb = EXT_W'(ctrb);
    ra = nega4 ? (ea - $signed({1'b0, rnda4})) : (ea + $signed({1'b0, rnda4}));
    rb = negb4 ? (eb - $signed({1'b0, rndb4})) : (eb + $signed({1'b0, rndb4}));
    hita = (ra > HI) || (ra < LO);
    hitb = (rb > HI) || (rb < LO);
    qa = clamp_coord(ra);
    qb = clamp_coord(rb);
    res_next.rotated_x = cx4.item.point_x;
    res_next.rotated_y = cx4.item.point_y;
    res_next.rotated_z = cx4.item.point_z;
    res_next.saturated = hita || hitb;
    unique case (cx4.item.axis)
      AXIS_X: begin
        res_next.rotated_y = qa;
        res_next.rotated_z = qb;
      end
      AXIS_Y: begin
        res_next.rotated_z = qa;
        res_next.rotated_x = qb;
      end
      AXIS_Z: begin
        res_next.rotated_x = qa;
        res_next.rotated_y = qb;
      end
      AXIS_NONE: begin
        res_next.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx1 <= in_ctx;
      cos1 <= clamp_trig(c_raw);
      sin1 <= clamp_trig(s_raw);
      cx2 <= cx1;
      ca2 <= PROD_W'(cos1) * PROD_W'(cx1.da);
      sb2 <= PROD_W'(sin1) * PROD_W'(cx1.db);
      sa2 <= PROD_W'(sin1) * PROD_W'(cx1.da);
      cb2 <= PROD_W'(cos1) * PROD_W'(cx1.db);
      cx3 <= cx2;
      suma3 <= SUM_W'(ca2) - SUM_W'(sb2);
      sumb3 <= SUM_W'(sa2) + SUM_W'(cb2);
      cx4 <= cx3;
      nega4 <= suma3[SUM_W-1];
      negb4 <= sumb3[SUM_W-1];
      rnda4 <= maga[SUM_W-1:30];
      rndb4 <= magb[SUM_W-1:30];
      out_data <= res_next;
    end
  end

endmodule

// ----- rtl/point_axis_rotation_unit.sv -----
// Top level: rotation pipeline with an output register and skid stage.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+---------------------
//   point    | in        | point_valid / point_ready   | point   (point_t)
//   result   | out       | result_valid / result_ready | result  (result_t)
//
// One point per cycle sustained while the skid stage is empty. A point is loaded
// into the input stage at its transfer edge, then passes one register per
// micro-rotation, five back-end stages and the output register.
// rst is synchronous and clears only the valid bits.
// A stalled result is held in the output register; one more in-flight result
// lands in the skid stage, and point_ready drops while the skid stage is full.
module point_axis_rotation_unit import par_pkg::*; #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    point_valid,
  output logic    point_ready,
  input  point_t  point,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    en;
  logic    prep_valid, cord_valid, mix_valid;
  ctx_t    prep_ctx, cord_ctx;
  cord_t   prep_cord, cord_cord;
  result_t mix_data;
  logic    skid_valid;
  result_t skid_data;

  assign en = !skid_valid;
  assign point_ready = !skid_valid;

  par_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (point_valid),
    .item      (point),
    .out_valid (prep_valid),
    .ctx       (prep_ctx),
    .cord      (prep_cord)
  );

  par_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .in_ctx    (prep_ctx),
    .in_cord   (prep_cord),
    .out_valid (cord_valid),
    .out_ctx   (cord_ctx),
    .out_cord  (cord_cord)
  );

  par_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cord_valid),
    .in_ctx    (cord_ctx),
    .in_cord   (cord_cord),
    .out_valid (mix_valid),
    .out_data  (mix_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result_ready || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        result_valid <= mix_valid;
      end
    end else if (en && mix_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready || !result_valid) begin
      result <= skid_valid ? skid_data : mix_data;
    end else if (en && mix_valid) begin
      skid_data <= mix_data;
    end
  end

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && !result_ready))
    else $error("skid stage filled without a stalled output");

  a_skid_drain_to_output: assert property (@(posedge clk) disable iff (rst)
    $fell(skid_valid) |-> result_valid)
    else $error("skid stage drained but no result presented");

endmodule

// ----- tb/point_axis_rotation_unit_test.sv -----
// Testbench for the point axis rotation unit: directed table, random points, CORDIC predictor.
module point_axis_rotation_unit_test import par_pkg::*;;

  localparam int     STAGES       = 18;
  localparam int     N_DIRECTED   = 20;
  localparam int     N_RANDOM     = 650;
  localparam int     SETTLE       = 40;
  localparam longint CORDIC_GAIN  = 652032874;
  localparam longint UNIT         = 64'sd1 << 30;
  localparam longint ROUND_HALF   = 64'sd1 << 29;
  localparam longint EIGHTH       = 64'sd1 << 29;
  localparam longint LIMIT_HI     = 32767;
  localparam longint LIMIT_LO     = -32768;
  localparam coord_t CMAX         = 16'sh7FFF;
  localparam coord_t CMIN         = 16'sh8000;

  localparam logic [31:0] ARCTAN_STEPS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    point_t  pt;
    bit      known;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{CMAX, CMAX, CMAX, 16'hFFFF, AXIS_NONE, CMIN, CMIN, CMIN}, 1'b1,
      '{CMAX, CMAX, CMAX, 1'b0}},
    '{'{CMIN, CMIN, CMIN, 16'h0000, AXIS_NONE, CMAX, CMAX, CMAX}, 1'b1,
      '{CMIN, CMIN, CMIN, 1'b0}},
    '{'{16'sd1234, -16'sd777, 16'sd42, 16'h1234, AXIS_X, 16'sd1234, -16'sd777, 16'sd42}, 1'b1,
      '{16'sd1234, -16'sd777, 16'sd42, 1'b0}},
    '{'{CMIN, CMAX, CMIN, 16'hABCD, AXIS_Y, CMIN, CMAX, CMIN}, 1'b1,
      '{CMIN, CMAX, CMIN, 1'b0}},
    '{'{CMAX, CMAX, 16'sd0, 16'h8000, AXIS_Z, CMIN, CMIN, 16'sd0}, 1'b1,
      '{CMIN, CMIN, 16'sd0, 1'b1}},
    '{'{16'sd0, CMAX, CMAX, 16'h8000, AXIS_X, 16'sd0, CMIN, CMIN}, 1'b1,
      '{16'sd0, CMIN, CMIN, 1'b1}},
    '{'{CMAX, 16'sd0, CMAX, 16'h8000, AXIS_Y, CMIN, 16'sd0, CMIN}, 1'b1,
      '{CMIN, 16'sd0, CMIN, 1'b1}},
    '{'{CMIN, CMIN, 16'sd5, 16'h8000, AXIS_Z, CMAX, CMAX, CMIN}, 1'b1,
      '{CMAX, CMAX, 16'sd5, 1'b1}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'h0000, AXIS_X, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{'{16'sd1000, 16'sd0, 16'sd7, 16'h4000, AXIS_Z, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd1000, -16'sd2000, 16'sd3000, 16'h2000, AXIS_X, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd1000, -16'sd2000, 16'sd3000, 16'h6000, AXIS_Y, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{CMAX, CMAX, CMAX, 16'hC000, AXIS_Z, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{CMAX, CMIN, CMAX, 16'hE000, AXIS_X, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd12345, -16'sd23456, 16'sd321, 16'hFFFF, AXIS_Z, -16'sd100, 16'sd200, -16'sd300},
      1'b0, '0},
    '{'{-16'sd5, 16'sd5, -16'sd5, 16'h1FFF, AXIS_Y, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
    '{'{16'sd100, 16'sd200, 16'sd300, 16'h0001, AXIS_X, CMIN, CMAX, CMIN}, 1'b0, '0},
    '{'{CMIN, CMIN, CMIN, 16'h2000, AXIS_Z, CMAX, CMAX, CMAX}, 1'b0, '0},
    '{'{16'sd3, 16'sd0, 16'sd0, 16'h5555, AXIS_Z, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd20000, 16'sd20000, 16'sd0, 16'hA000, AXIS_Y, 16'sd77, -16'sd77, 16'sd9}, 1'b0, '0}
  };

  logic    clk = 1'b0;
  logic    rst;
  logic    point_valid;
  logic    point_ready;
  point_t  point;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  result_t pending_rotations [$];
  int      mismatches     = 0;
  int      sender_burst   = 0;
  int      receiver_burst = 0;

  point_axis_rotation_unit #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk,
    .rst,
    .point_valid,
    .point_ready,
    .point,
    .result_valid,
    .result_ready,
    .result
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void cos_sin_of(input logic [ANGLE_WIDTH-1:0] angle,
                                     output longint c, output longint s);
    logic [31:0] turned;
    longint x;
    longint y;
    longint x_sh;
    longint y_sh;
    longint resid;
    turned = {angle, 16'h0000} + 32'h2000_0000;
    resid = longint'(turned[29:0]) - EIGHTH;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      x_sh = x >>> i;
      y_sh = y >>> i;
      if (resid >= 0) begin
        x = x - y_sh;
        y = y + x_sh;
        resid = resid - longint'(ARCTAN_STEPS[i]);
      end else begin
        x = x + y_sh;
        y = y - x_sh;
        resid = resid + longint'(ARCTAN_STEPS[i]);
      end
    end
    case (turned[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = (c > UNIT) ? UNIT : (c < -UNIT) ? -UNIT : c;
    s = (s > UNIT) ? UNIT : (s < -UNIT) ? -UNIT : s;
  endfunction

  function automatic longint round_half_away(input longint v);
    if (v >= 0) return (v + ROUND_HALF) >>> 30;
    return -((-v + ROUND_HALF) >>> 30);
  endfunction

  function automatic result_t rotate_point(input point_t p);
    longint  pt [3];
    longint  ctr [3];
    longint  d [3];
    longint  r [3];
    longint  c;
    longint  s;
    int      ia;
    int      ib;
    bit      clamped;
    result_t res;
    pt[0]  = p.point_x;
    pt[1]  = p.point_y;
    pt[2]  = p.point_z;
    ctr[0] = p.center_x;
    ctr[1] = p.center_y;
    ctr[2] = p.center_z;
    clamped = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d[k] = pt[k] - ctr[k];
      r[k] = pt[k];
    end
    if (p.axis != AXIS_NONE) begin
      cos_sin_of(p.angle, c, s);
      case (p.axis)
        AXIS_X:  begin ia = 1; ib = 2; end
        AXIS_Y:  begin ia = 2; ib = 0; end
        default: begin ia = 0; ib = 1; end
      endcase
      r[ia] = round_half_away(c * d[ia] - s * d[ib]) + ctr[ia];
      r[ib] = round_half_away(s * d[ia] + c * d[ib]) + ctr[ib];
      for (int k = 0; k < 3; k++) begin
        if (r[k] > LIMIT_HI) begin
          r[k] = LIMIT_HI;
          clamped = 1'b1;
        end else if (r[k] < LIMIT_LO) begin
          r[k] = LIMIT_LO;
          clamped = 1'b1;
        end
      end
    end
    res.rotated_x = coord_t'(r[0]);
    res.rotated_y = coord_t'(r[1]);
    res.rotated_z = coord_t'(r[2]);
    res.saturated = clamped;
    return res;
  endfunction

  function automatic coord_t random_coord(input int span);
    return coord_t'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  function automatic point_t make_random_point();
    point_t p;
    int     span;
    int     cspan;
    if ($urandom_range(0, 3) == 0) begin
      span  = 32768;
      cspan = 32768;
    end else begin
      span  = 12000;
      cspan = 8000;
    end
    p.point_x  = random_coord(span);
    p.point_y  = random_coord(span);
    p.point_z  = random_coord(span);
    p.center_x = random_coord(cspan);
    p.center_y = random_coord(cspan);
    p.center_z = random_coord(cspan);
    if ($urandom_range(0, 4) == 0)
      p.angle = 16'($urandom_range(0, 7) * 32'h2000 + $urandom_range(0, 2) - 1);
    else
      p.angle = 16'($urandom);
    p.axis = axis_t'(2'($urandom_range(0, 3)));
    return p;
  endfunction

  task automatic draw_wait(inout int burst_left, output int cycles);
    if (burst_left == 0 && $urandom_range(0, 15) == 0)
      burst_left = $urandom_range(10, 40);
    if (burst_left > 0) begin
      burst_left--;
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 4);
    end
  endtask

  task automatic send_point(input point_t pt, input bit known, input result_t want);
    int gap;
    draw_wait(sender_burst, gap);
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_valid <= 1'b1;
    point       <= pt;
    @(posedge clk);
    while (!point_ready) @(posedge clk);
    pending_rotations.push_back(known ? want : rotate_point(pt));
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_rotations.size() == 0) begin
      $display("%0t: unexpected result %0d %0d %0d %0d", $time,
               got.rotated_x, got.rotated_y, got.rotated_z, got.saturated);
      mismatches++;
    end else begin
      want = pending_rotations.pop_front();
      report_field("rotated_x", want.rotated_x, got.rotated_x);
      report_field("rotated_y", want.rotated_y, got.rotated_y);
      report_field("rotated_z", want.rotated_z, got.rotated_z);
      report_field("saturated", want.saturated, got.saturated);
    end
  endtask

  initial begin
    rst          = 1'b1;
    point_valid  = 1'b0;
    point        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[n])
      send_point(directed_rows[n].pt, directed_rows[n].known, directed_rows[n].want);
    repeat (N_RANDOM) send_point(make_random_point(), 1'b0, '0);
    point_valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_rotations.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    int stall;
    result_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      draw_wait(receiver_burst, stall);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      check_result(result);
      @(negedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/par_pkg.sv
rtl/par_prep.sv
rtl/par_cordic.sv
rtl/par_mix.sv
rtl/point_axis_rotation_unit.sv
tb/point_axis_rotation_unit_test.sv
